// ===== rtl/sqvs_pkg.sv =====
// shared types, constants and table functions for the sprite quad vertex setup block
`timescale 1ns / 1ps
package sqvs_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int COORD_FRAC_BITS_DEF  = 4;

    // divider geometry
    localparam int NUM_W   = 40;          // signed numerator width
    localparam int QUOT_W  = 17;          // quotient bits before saturation
    localparam int DIV_LAT = QUOT_W + 1;  // divider pipeline depth

    localparam int QUEUE_DEPTH = 2;
    localparam int VERTS       = 6;

    typedef enum logic [1:0] {
        REG_VP_W  = 2'd0,
        REG_VP_H  = 2'd1,
        REG_TEX_W = 2'd2,
        REG_TEX_H = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [13:0] vp_w;
        logic [13:0] vp_h;
        logic [12:0] tex_w;
        logic [12:0] tex_h;
    } t_cfg;

    // classified sprite handed from front to back
    typedef struct packed {
        logic signed [15:0] sn;
        logic signed [15:0] cs;
        logic signed [17:0] w;
        logic signed [17:0] h;
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic [16:0]        u0;
        logic [16:0]        u1;
        logic [16:0]        v0;
        logic [16:0]        v1;
        logic [31:0]        color;
    } t_sprite;

    // corner for each emitted vertex: 0,1,2,2,1,3
    function automatic logic [1:0] corner_of(input logic [2:0] idx);
        logic [1:0] c;
        unique case (idx)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd2;
            3'd4:    c = 2'd1;
            default: c = 2'd3;
        endcase
        return c;
    endfunction

    // sin of a quarter turn fraction r/16384, q14
    function automatic logic [15:0] quarter_sine(input logic [14:0] r);
        logic [63:0] x, x2, p, s;
        x  = 64'(r) << 16;
        x2 = (x * x) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995    - ((x2 * p) >> 30);
        p  = 64'd85569306   - ((x2 * p) >> 30);
        p  = 64'd693598668  - ((x2 * p) >> 30);
        p  = 64'd1686629713 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        s  = (s + 64'd32768) >> 16;
        if (s > 64'd16384) s = 64'd16384;
        return s[15:0];
    endfunction

    function automatic logic signed [15:0] sine_q14(input logic [15:0] a);
        logic [1:0]  q;
        logic [13:0] r;
        logic [15:0] v;
        q = a[15:14];
        r = a[13:0];
        v = q[0] ? quarter_sine(15'd16384 - 15'(r)) : quarter_sine(15'(r));
        return q[1] ? -signed'(v) : signed'(v);
    endfunction

endpackage

// ===== rtl/sqvs_front.sv =====
// front: accepts sprite requests, looks up sine and cosine, precomputes centers
`timescale 1ns / 1ps
module sqvs_front import sqvs_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [17:0] i_pos_x,
    input  logic signed [17:0] i_pos_y,
    input  logic signed [17:0] i_rect_width,
    input  logic signed [17:0] i_rect_height,
    input  logic [31:0]        i_color_rgba,
    input  logic [15:0]        i_rotation,
    input  logic [15:0]        i_src_x,
    input  logic [15:0]        i_src_y,
    input  logic [15:0]        i_src_width,
    input  logic [15:0]        i_src_height,
    input  logic               i_q_full,
    output logic               o_push,
    output t_sprite            o_sprite
);

    localparam int IDX_W  = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
    localparam int PROD_W = 16 + IDX_W + 1;

    typedef logic signed [15:0] t_tab [SINE_TABLE_DEPTH];

    function automatic t_tab make_tab(input bit cosine);
        t_tab        t;
        logic [15:0] a;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
            a = 16'((longint'(k) * 65536) / SINE_TABLE_DEPTH);
            t[k] = sine_q14(cosine ? a + 16'd16384 : a);
        end
        return t;
    endfunction

    localparam t_tab SIN_TAB = make_tab(1'b0);
    localparam t_tab COS_TAB = make_tab(1'b1);

    logic              r_valid;
    t_sprite           r_sprite;
    logic              accept;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  k;
    t_sprite           n_sprite;

    assign o_busy = r_valid && i_q_full;
    assign accept = i_start && !o_busy;
    assign o_push = r_valid && !i_q_full;
    assign o_sprite = r_sprite;

    always_comb begin
        prod = PROD_W'(i_rotation) * PROD_W'(SINE_TABLE_DEPTH);
        k    = prod[16 +: IDX_W];
        n_sprite.sn    = SIN_TAB[k];
        n_sprite.cs    = COS_TAB[k];
        n_sprite.w     = i_rect_width;
        n_sprite.h     = i_rect_height;
        n_sprite.cx    = (20'(i_pos_x) <<< 1) + 20'(i_rect_width);
        n_sprite.cy    = (20'(i_pos_y) <<< 1) + 20'(i_rect_height);
        n_sprite.u0    = 17'(i_src_x);
        n_sprite.u1    = 17'(i_src_x) + 17'(i_src_width);
        n_sprite.v0    = 17'(i_src_y);
        n_sprite.v1    = 17'(i_src_y) + 17'(i_src_height);
        n_sprite.color = i_color_rgba;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sprite <= n_sprite;
        end
    end

endmodule

// ===== rtl/sqvs_queue.sv =====
// short sprite queue between front and back
`timescale 1ns / 1ps
module sqvs_queue import sqvs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_sprite i_sprite,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_sprite o_sprite
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_sprite         r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_pop;

    assign o_full   = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_sprite = r_mem[r_rp];
    assign do_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_sprite;
        end
    end

endmodule

// ===== rtl/sqvs_div.sv =====
// pipelined restoring divider, signed numerator, floor quotient, one bit a stage
`timescale 1ns / 1ps
module sqvs_div import sqvs_pkg::*; #(
    parameter int DEN_W = 19
) (
    input  logic                    i_clk,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic [QUOT_W-1:0]       o_quot,
    output logic                    o_neg,
    output logic                    o_ovf
);

    localparam int MAG_W = NUM_W - 1;
    localparam int EXT_W = (MAG_W > DEN_W) ? MAG_W : DEN_W;

    logic [DEN_W-1:0]  r_rem [QUOT_W+1];
    logic [QUOT_W-1:0] r_low [QUOT_W+1];
    logic [QUOT_W-1:0] r_q   [QUOT_W+1];
    logic              r_neg [QUOT_W+1];
    logic              r_ovf [QUOT_W+1];

    logic [MAG_W-1:0]  mag;
    logic [MAG_W-1:0]  hi;

    // floor for negatives: ~n / d, then complement
    assign mag = i_num[NUM_W-1] ? ~i_num[MAG_W-1:0] : i_num[MAG_W-1:0];
    assign hi  = mag >> QUOT_W;

    always_ff @(posedge i_clk) begin
        logic [DEN_W:0] trial;
        r_rem[0] <= DEN_W'(hi);
        r_low[0] <= mag[QUOT_W-1:0];
        r_q[0]   <= '0;
        r_neg[0] <= i_num[NUM_W-1];
        r_ovf[0] <= (EXT_W'(hi) >= EXT_W'(i_den));
        for (int s = 0; s < QUOT_W; s++) begin
            trial = {r_rem[s], r_low[s][QUOT_W-1-s]};
            if (trial >= {1'b0, i_den}) begin
                r_rem[s+1] <= DEN_W'(trial - {1'b0, i_den});
                r_q[s+1]   <= {r_q[s][QUOT_W-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= DEN_W'(trial);
                r_q[s+1]   <= {r_q[s][QUOT_W-2:0], 1'b0};
            end
            r_low[s+1] <= r_low[s];
            r_neg[s+1] <= r_neg[s];
            r_ovf[s+1] <= r_ovf[s];
        end
    end

    assign o_quot = r_q[QUOT_W];
    assign o_neg  = r_neg[QUOT_W];
    assign o_ovf  = r_ovf[QUOT_W];

endmodule

// ===== rtl/sqvs_back.sv =====
// back: vertex sequencer, corner rotation, division pipelines and output formatting
`timescale 1ns / 1ps
module sqvs_back import sqvs_pkg::*; #(
    parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_sprite            i_sprite,
    output logic               o_pop,
    output logic               o_valid,
    output logic signed [15:0] o_ndc_x,
    output logic signed [15:0] o_ndc_y,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic [31:0]        o_vertex_color,
    output logic               o_last_vertex
);

    localparam int DEN_W = 15 + COORD_FRAC_BITS;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [31:0]        color;
        logic signed [34:0] pcx;
        logic signed [34:0] psy;
        logic signed [34:0] psx;
        logic signed [34:0] pcy;
        logic signed [19:0] cx;
        logic signed [19:0] cy;
        logic [16:0]        su;
        logic [16:0]        sv;
    } t_stage_a;

    // sequencer
    logic      r_busy;
    logic [2:0] r_cnt;
    t_sprite   r_cur;

    assign o_pop = i_q_valid && (!r_busy || r_cnt == 3'(VERTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == 3'(VERTS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_sprite;
        end
    end

    // divisors, zero taken as one, doubled for the rounding form
    logic [DEN_W-1:0] d_x, d_y, d_u, d_v;

    function automatic logic [DEN_W-1:0] half_den(input logic [13:0] reg_val);
        logic [13:0] v;
        v = (reg_val == '0) ? 14'd1 : reg_val;
        return DEN_W'(v) << COORD_FRAC_BITS;
    endfunction

    assign d_x = half_den(i_cfg.vp_w);
    assign d_y = half_den(i_cfg.vp_h);
    assign d_u = half_den(14'(i_cfg.tex_w));
    assign d_v = half_den(14'(i_cfg.tex_h));

    // stage a: corner offsets times sine and cosine
    t_stage_a           r_a;
    logic [1:0]         corner;
    logic signed [18:0] tx, ty;

    always_comb begin
        corner = corner_of(r_cnt);
        tx = corner[0] ? 19'(r_cur.w) : -19'(r_cur.w);
        ty = corner[1] ? 19'(r_cur.h) : -19'(r_cur.h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else begin
            r_a.valid <= r_busy;
        end
        r_a.last  <= (r_cnt == 3'(VERTS - 1));
        r_a.color <= r_cur.color;
        r_a.pcx   <= r_cur.cs * tx;
        r_a.psy   <= r_cur.sn * ty;
        r_a.psx   <= r_cur.sn * tx;
        r_a.pcy   <= r_cur.cs * ty;
        r_a.cx    <= r_cur.cx;
        r_a.cy    <= r_cur.cy;
        r_a.su    <= corner[0] ? r_cur.u1 : r_cur.u0;
        r_a.sv    <= corner[1] ? r_cur.v1 : r_cur.v0;
    end

    // stage b: numerators 2n + d
    logic signed [NUM_W-1:0] r_nx, r_ny, r_nu, r_nv;
    logic                    r_b_valid, r_b_last;
    logic [31:0]             r_b_color;

    always_ff @(posedge i_clk) begin
        logic [NUM_W-1:0] x, y;
        x = (NUM_W'(r_a.cx) << 14) + NUM_W'(r_a.pcx) - NUM_W'(r_a.psy);
        y = (NUM_W'(r_a.cy) << 14) + NUM_W'(r_a.psx) + NUM_W'(r_a.pcy);
        r_nx <= (x << 1) + NUM_W'(d_x);
        r_ny <= (y << 1) + NUM_W'(d_y);
        r_nu <= (NUM_W'(r_a.su) << 15) + NUM_W'(d_u);
        r_nv <= (NUM_W'(r_a.sv) << 15) + NUM_W'(d_v);
        r_b_last  <= r_a.last;
        r_b_color <= r_a.color;
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a.valid;
        end
    end

    logic [QUOT_W-1:0] q_x, q_y, q_u, q_v;
    logic              n_x, n_y, n_u, n_v;
    logic              v_x, v_y, v_u, v_v;

    sqvs_div #(.DEN_W(DEN_W)) u_div_x (
        .i_clk(i_clk), .i_num(r_nx), .i_den(DEN_W'(d_x << 1)),
        .o_quot(q_x), .o_neg(n_x), .o_ovf(v_x)
    );
    sqvs_div #(.DEN_W(DEN_W)) u_div_y (
        .i_clk(i_clk), .i_num(r_ny), .i_den(DEN_W'(d_y << 1)),
        .o_quot(q_y), .o_neg(n_y), .o_ovf(v_y)
    );
    sqvs_div #(.DEN_W(DEN_W)) u_div_u (
        .i_clk(i_clk), .i_num(r_nu), .i_den(DEN_W'(d_u << 1)),
        .o_quot(q_u), .o_neg(n_u), .o_ovf(v_u)
    );
    sqvs_div #(.DEN_W(DEN_W)) u_div_v (
        .i_clk(i_clk), .i_num(r_nv), .i_den(DEN_W'(d_v << 1)),
        .o_quot(q_v), .o_neg(n_v), .o_ovf(v_v)
    );

    // side band follows the dividers
    logic        r_dv    [DIV_LAT];
    logic        r_dlast [DIV_LAT];
    logic [31:0] r_dcol  [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_dv[i] <= 1'b0;
        end else begin
            r_dv[0] <= r_b_valid;
            for (int i = 1; i < DIV_LAT; i++) r_dv[i] <= r_dv[i-1];
        end
        r_dlast[0] <= r_b_last;
        r_dcol[0]  <= r_b_color;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_dlast[i] <= r_dlast[i-1];
            r_dcol[i]  <= r_dcol[i-1];
        end
    end

    // signed floor quotient, overflow pinned far outside every output range
    function automatic logic signed [19:0] quot_val(input logic [QUOT_W-1:0] q,
                                                    input logic neg, input logic ovf);
        logic signed [19:0] v;
        if (ovf) begin
            v = neg ? -20'sd262144 : 20'sd262143;
        end else begin
            v = neg ? ~20'(q) : 20'(q);
        end
        return v;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd32767) r = 16'sh7fff;
        else if (v < -21'sd32768) r = 16'sh8000;
        else r = 16'(v);
        return r;
    endfunction

    function automatic logic [15:0] satu16(input logic signed [19:0] v);
        logic [15:0] r;
        if (v < 20'sd0) r = 16'd0;
        else if (v > 20'sd65535) r = 16'hffff;
        else r = 16'(v);
        return r;
    endfunction

    logic r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_dv[DIV_LAT-1];
        end
        o_ndc_x        <= sat16(21'(quot_val(q_x, n_x, v_x)) - 21'sd16384);
        o_ndc_y        <= sat16(21'sd16384 - 21'(quot_val(q_y, n_y, v_y)));
        o_tex_u        <= satu16(quot_val(q_u, n_u, v_u));
        o_tex_v        <= satu16(quot_val(q_v, n_v, v_v));
        o_vertex_color <= r_dcol[DIV_LAT-1];
        o_last_vertex  <= r_dlast[DIV_LAT-1] && r_dv[DIV_LAT-1];
    end

    assign o_valid = r_valid;

endmodule

// ===== rtl/sprite_quad_vertex_setup.sv =====
// top level: sprite to two ndc triangles, config registers, front, queue and back
//
//  channel   direction  handshake                  payload
//  request   in         start & !busy              pos, rect, color, rotation, src rect
//  vertex    out        o_valid, one cycle each    ndc x/y, tex u/v, color, last flag
//  config    in         psel & penable & pwrite    four divisor registers, pready tied high
//
// one sprite yields six vertices on consecutive cycles, as the back sequencer issues one
// vertex a cycle while busy and pops the next queued sprite with its last vertex
// a request passes the front register, the queue, the sequencer, two math stages, the
// 17-bit divider pipeline and the output register before its first vertex
// a two-entry queue lets the front take requests while the back is still emitting;
// busy rises only when the front register and the queue are both full
// synchronous active-low reset clears control state and loads register defaults
// results cannot be held off, they appear for exactly one cycle each
`timescale 1ns / 1ps
module sprite_quad_vertex_setup import sqvs_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request
    input  logic               start,
    output logic               busy,
    input  logic signed [17:0] i_pos_x,
    input  logic signed [17:0] i_pos_y,
    input  logic signed [17:0] i_rect_width,
    input  logic signed [17:0] i_rect_height,
    input  logic [31:0]        i_color_rgba,
    input  logic [15:0]        i_rotation,
    input  logic [15:0]        i_src_x,
    input  logic [15:0]        i_src_y,
    input  logic [15:0]        i_src_width,
    input  logic [15:0]        i_src_height,
    // vertex out
    output logic               o_valid,
    output logic signed [15:0] o_ndc_x,
    output logic signed [15:0] o_ndc_y,
    output logic [15:0]        o_tex_u,
    output logic [15:0]        o_tex_v,
    output logic [31:0]        o_vertex_color,
    output logic               o_last_vertex,
    // config
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // config registers
    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vp_w  <= 14'd1920;
            r_cfg.vp_h  <= 14'd1080;
            r_cfg.tex_w <= 13'd256;
            r_cfg.tex_h <= 13'd256;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_VP_W:  r_cfg.vp_w  <= pwdata[13:0];
                REG_VP_H:  r_cfg.vp_h  <= pwdata[13:0];
                REG_TEX_W: r_cfg.tex_w <= pwdata[12:0];
                REG_TEX_H: r_cfg.tex_h <= pwdata[12:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VP_W:  prdata = 32'(r_cfg.vp_w);
            REG_VP_H:  prdata = 32'(r_cfg.vp_h);
            REG_TEX_W: prdata = 32'(r_cfg.tex_w);
            REG_TEX_H: prdata = 32'(r_cfg.tex_h);
        endcase
    end

    // front to queue to back
    logic    q_full, push, pop, q_valid;
    t_sprite f_sprite, q_sprite;

    sqvs_front #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_color_rgba  (i_color_rgba),
        .i_rotation    (i_rotation),
        .i_src_x       (i_src_x),
        .i_src_y       (i_src_y),
        .i_src_width   (i_src_width),
        .i_src_height  (i_src_height),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_sprite      (f_sprite)
    );

    sqvs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sprite (f_sprite),
        .o_full   (q_full),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_sprite (q_sprite)
    );

    sqvs_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_q_valid      (q_valid),
        .i_sprite       (q_sprite),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_ndc_x        (o_ndc_x),
        .o_ndc_y        (o_ndc_y),
        .o_tex_u        (o_tex_u),
        .o_tex_v        (o_tex_v),
        .o_vertex_color (o_vertex_color),
        .o_last_vertex  (o_last_vertex)
    );

endmodule

// ===== rtl/sqvs_checker.sv =====
// port-level checks on vertex framing and the config port, bound to the top level
`timescale 1ns / 1ps
module sqvs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic o_last_vertex,
    input logic pready
);

    // vertices of one sprite come out on consecutive cycles
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_vertex |=> o_valid)
        else $error("vertex burst broken before last vertex");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_vertex |-> o_valid)
        else $error("last flag without vertex strobe");

    // sixth vertex: five strobes without last before it
    a_six: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_vertex |-> $past(o_valid, 5) && !$past(o_last_vertex, 1)
            && !$past(o_last_vertex, 2) && !$past(o_last_vertex, 3)
            && !$past(o_last_vertex, 4) && !$past(o_last_vertex, 5))
        else $error("last vertex not sixth of a sprite");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("vertex strobe right after reset");

    // config port never inserts wait states
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind sprite_quad_vertex_setup sqvs_checker u_sqvs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .o_last_vertex (o_last_vertex),
    .pready        (pready)
);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench for the sprite quad vertex setup block
`timescale 1ns / 1ps
module tb_top;
    import sqvs_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int FRAC_BITS   = 4;
    // request to first vertex plus the vertices of one sprite, with margin
    localparam int DRAIN_CYCLES = 40;

    // one predicted vertex
    typedef struct {
        logic signed [15:0] ndc_x;
        logic signed [15:0] ndc_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [31:0]        color;
        logic               last;
    } t_vertex;

    // one sprite request
    typedef struct {
        logic signed [17:0] px, py, w, h;
        logic [31:0]        color;
        logic [15:0]        rot, sx, sy, sw, sh;
    } t_req;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [17:0] pos_x, pos_y, rect_w, rect_h;
    logic [31:0]        color_rgba;
    logic [15:0]        rotation, src_x, src_y, src_w, src_h;
    logic               o_valid;
    logic signed [15:0] o_ndc_x, o_ndc_y;
    logic [15:0]        o_tex_u, o_tex_v;
    logic [31:0]        o_vertex_color;
    logic               o_last_vertex;
    logic               psel, penable, pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;

    // shadow copy of the divisor registers
    logic [13:0] vp_w_q, vp_h_q;
    logic [12:0] tex_w_q, tex_h_q;

    t_vertex pending_vertices[$];
    int      mismatch_count;
    bit      allow_idle;

    sprite_quad_vertex_setup dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_rect_width(rect_w), .i_rect_height(rect_h),
        .i_color_rgba(color_rgba), .i_rotation(rotation),
        .i_src_x(src_x), .i_src_y(src_y), .i_src_width(src_w), .i_src_height(src_h),
        .o_valid, .o_ndc_x, .o_ndc_y, .o_tex_u, .o_tex_v, .o_vertex_color, .o_last_vertex,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit, far above the slowest correct run
    initial begin
        #2000000;
        $display("[sprite_quad_vertex_setup] ERROR");
        $finish;
    end

    // sine of a quarter-turn fraction r/16384 in q14, odd polynomial with q30 coefficients
    function automatic longint quarter_turn_sine(input longint unsigned r);
        longint unsigned x, x2, p, s;
        x  = r << 16;
        x2 = (x * x) >> 30;
        p  = 172272;
        p  = 5026995 - ((x2 * p) >> 30);
        p  = 85569306 - ((x2 * p) >> 30);
        p  = 693598668 - ((x2 * p) >> 30);
        p  = 1686629713 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        s  = (s + 32768) >> 16;
        if (s > 16384) s = 16384;
        return longint'(s);
    endfunction

    // full-turn sine by quadrant fold, angle in 65536 units
    function automatic longint angle_sine(input longint unsigned a);
        longint unsigned q, r;
        longint          v;
        q = (a >> 14) & 3;
        r = a & 16'h3FFF;
        v = q[0] ? quarter_turn_sine(16384 - r) : quarter_turn_sine(r);
        return q[1] ? -v : v;
    endfunction

    // round to nearest, ties toward plus infinity
    function automatic longint div_round(input longint n, input longint d);
        longint nn, dd, q;
        nn = 2 * n + d;
        dd = 2 * d;
        q  = nn / dd;
        if ((nn % dd) != 0 && nn < 0) q -= 1;
        return q;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // a zero register acts as one
    function automatic longint scaled_divisor(input longint unsigned reg_val);
        return (reg_val == 0 ? 64'sd1 : longint'(reg_val)) << FRAC_BITS;
    endfunction

    // work out the six vertices of a sprite and queue them
    task automatic queue_sprite_vertices(input t_req s);
        longint        k, sn, cs, cx, cy, dvx, dvy, dtu, dtv, tx, ty, big_x, big_y;
        longint        u0, u1, v0, v1;
        longint        nx[4], ny[4];
        longint unsigned ang;
        int            corner_order[6];
        t_vertex       v;
        corner_order = '{0, 1, 2, 2, 1, 3};
        k   = (longint'(s.rot) * TABLE_DEPTH) >> 16;
        ang = ((k << 16) / TABLE_DEPTH) & 16'hFFFF;
        sn  = angle_sine(ang);
        cs  = angle_sine((ang + 16384) & 16'hFFFF);
        dvx = scaled_divisor(vp_w_q);
        dvy = scaled_divisor(vp_h_q);
        dtu = scaled_divisor(tex_w_q);
        dtv = scaled_divisor(tex_h_q);
        // doubled center keeps everything integral
        cx = (2 * longint'(s.px) + longint'(s.w)) * 16384;
        cy = (2 * longint'(s.py) + longint'(s.h)) * 16384;
        for (int c = 0; c < 4; c++) begin
            tx = c[0] ? longint'(s.w) : -longint'(s.w);
            ty = c[1] ? longint'(s.h) : -longint'(s.h);
            big_x = cx + cs * tx - sn * ty;
            big_y = cy + sn * tx + cs * ty;
            nx[c] = clamp(div_round(big_x, dvx) - 16384, -32768, 32767);
            ny[c] = clamp(16384 - div_round(big_y, dvy), -32768, 32767);
        end
        u0 = clamp(div_round(longint'(s.sx) * 16384, dtu), 0, 65535);
        u1 = clamp(div_round((longint'(s.sx) + longint'(s.sw)) * 16384, dtu), 0, 65535);
        v0 = clamp(div_round(longint'(s.sy) * 16384, dtv), 0, 65535);
        v1 = clamp(div_round((longint'(s.sy) + longint'(s.sh)) * 16384, dtv), 0, 65535);
        for (int i = 0; i < 6; i++) begin
            v.ndc_x = nx[corner_order[i]][15:0];
            v.ndc_y = ny[corner_order[i]][15:0];
            v.tex_u = corner_order[i][0] ? u1[15:0] : u0[15:0];
            v.tex_v = corner_order[i][1] ? v1[15:0] : v0[15:0];
            v.color = s.color;
            v.last  = (i == 5);
            pending_vertices = {pending_vertices, v};
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // random gap on the request side, start is dropped for its length
    task automatic maybe_idle();
        int n;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            @(negedge i_clk);
            start = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // present one request and hold it until the block takes it
    task automatic send_sprite(input t_req s);
        maybe_idle();
        @(negedge i_clk);
        start      = 1'b1;
        pos_x      = s.px;
        pos_y      = s.py;
        rect_w     = s.w;
        rect_h     = s.h;
        color_rgba = s.color;
        rotation   = s.rot;
        src_x      = s.sx;
        src_y      = s.sy;
        src_w      = s.sw;
        src_h      = s.sh;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        queue_sprite_vertices(s);
    endtask

    // drop start and let every expected vertex come out
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // apb write, setup then access; only while idle
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = 4'(idx) << 2;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_VP_W:  vp_w_q  = value[13:0];
            REG_VP_H:  vp_h_q  = value[13:0];
            REG_TEX_W: tex_w_q = value[12:0];
            REG_TEX_H: tex_h_q = value[12:0];
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_divisors(input int vw, input int vh, input int tw, input int th);
        write_reg(REG_VP_W, vw);
        write_reg(REG_VP_H, vh);
        write_reg(REG_TEX_W, tw);
        write_reg(REG_TEX_H, th);
    endtask

    function automatic t_req make_sprite(input int px, input int py, input int w,
                                         input int h, input logic [31:0] color,
                                         input int rot, input int sx, input int sy,
                                         input int sw, input int sh);
        t_req s;
        s.px = 18'(px); s.py = 18'(py); s.w = 18'(w); s.h = 18'(h); s.color = color;
        s.rot = 16'(rot); s.sx = 16'(sx); s.sy = 16'(sy); s.sw = 16'(sw); s.sh = 16'(sh);
        return s;
    endfunction

    // random sprite: mostly on-screen content, some full-range noise
    function automatic t_req random_sprite();
        t_req s;
        s.color = $urandom;
        s.rot   = 16'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            s.px = 18'($urandom_range(0, 2000 * 16) - 40 * 16);
            s.py = 18'($urandom_range(0, 1100 * 16) - 40 * 16);
            s.w  = 18'($urandom_range(0, 300 * 16));
            s.h  = 18'($urandom_range(0, 300 * 16));
            if ($urandom_range(0, 7) == 0) s.w = -s.w;
            if ($urandom_range(0, 7) == 0) s.h = -s.h;
            s.sx = 16'($urandom_range(0, 256 * 16));
            s.sy = 16'($urandom_range(0, 256 * 16));
            s.sw = 16'($urandom_range(0, 128 * 16));
            s.sh = 16'($urandom_range(0, 128 * 16));
        end else begin
            s.px = 18'($urandom); s.py = 18'($urandom);
            s.w  = 18'($urandom); s.h  = 18'($urandom);
            s.sx = 16'($urandom); s.sy = 16'($urandom);
            s.sw = 16'($urandom); s.sh = 16'($urandom);
        end
        return s;
    endfunction

    // field extremes, every quadrant, table step boundaries, mirrored and empty rectangles
    task automatic test_directed_sprites();
        send_sprite(make_sprite(0, 0, 0, 0, 32'h0, 0, 0, 0, 0, 0));
        send_sprite(make_sprite(100*16, 200*16, 64*16, 32*16, 32'hFFFFFFFF, 0,
                                0, 0, 16*16, 16*16));
        send_sprite(make_sprite(960*16, 540*16, 64*16, 64*16, 32'h12345678, 16384,
                                65535, 65535, 65535, 65535));
        send_sprite(make_sprite(960*16, 540*16, 64*16, 64*16, 32'h80808080, 32768,
                                8, 8, 8, 8));
        send_sprite(make_sprite(960*16, 540*16, 64*16, 64*16, 32'h7F7F7F7F, 49152,
                                1, 2, 3, 4));
        send_sprite(make_sprite(500*16, 300*16, 40*16, 20*16, 32'hA5A5A5A5, 65535,
                                100, 100, 200, 200));
        send_sprite(make_sprite(500*16, 300*16, 40*16, 20*16, 32'h5A5A5A5A, 255,
                                0, 0, 4096, 4096));
        send_sprite(make_sprite(500*16, 300*16, 40*16, 20*16, 32'h01020304, 256,
                                0, 0, 4096, 4096));
        send_sprite(make_sprite(500*16, 300*16, -40*16, -20*16, 32'hDEADBEEF, 8192,
                                0, 0, 4096, 4096));
        send_sprite(make_sprite(-131072, -131072, -131072, -131072, 32'hFF000000, 0,
                                0, 0, 0, 0));
        send_sprite(make_sprite(131071, 131071, 131071, 131071, 32'h000000FF, 0,
                                65535, 0, 65535, 0));
        send_sprite(make_sprite(131071, -131072, 131071, -131072, 32'h00FF00FF, 24576,
                                0, 65535, 0, 65535));
        send_sprite(make_sprite(-131072, 131071, 131071, 131071, 32'hFF00FF00, 40960,
                                32768, 32768, 32767, 32767));
        send_sprite(make_sprite(1, 1, 1, 1, 32'h11111111, 128, 1, 1, 1, 1));
        send_sprite(make_sprite(1920*16, 1080*16, 0, 16, 32'h22222222, 57344,
                                0, 0, 0, 16));
        wait_drained();
    endtask

    task automatic test_register_settings();
        t_req s;
        // zero registers behave as one
        set_divisors(0, 0, 0, 0);
        send_sprite(make_sprite(1, 1, 2, 2, 32'h0, 0, 1, 1, 1, 1));
        send_sprite(random_sprite());
        wait_drained();
        // smallest
        set_divisors(1, 1, 1, 1);
        for (int i = 0; i < 8; i++) begin
            s = random_sprite();
            s.px = 18'($urandom_range(0, 32) - 16);
            s.py = 18'($urandom_range(0, 32) - 16);
            s.w  = 18'($urandom_range(0, 16));
            s.h  = 18'($urandom_range(0, 16));
            s.sx = 16'($urandom_range(0, 16));
            s.sw = 16'($urandom_range(0, 16));
            send_sprite(s);
        end
        wait_drained();
        // top register bit alone, and all register bits high
        set_divisors(8192, 8192, 4096, 4096);
        for (int i = 0; i < 8; i++) send_sprite(random_sprite());
        wait_drained();
        set_divisors(16383, 16383, 8191, 8191);
        for (int i = 0; i < 8; i++) send_sprite(random_sprite());
        wait_drained();
        set_divisors(640, 480, 64, 32);
        for (int i = 0; i < 8; i++) send_sprite(random_sprite());
        wait_drained();
        set_divisors(1920, 1080, 256, 256);
    endtask

    task automatic test_random_sprites(input int count);
        for (int i = 0; i < count; i++) begin
            allow_idle = (i < count - 40);
            send_sprite(random_sprite());
            // hold off now and then until everything has come out
            if (i % 60 == 30) wait_drained();
        end
        allow_idle = 1'b0;
        wait_drained();
    endtask

    // vertex checker, one result per valid cycle
    always @(posedge i_clk) begin : check_vertices
        t_vertex e;
        if (i_rst_n && o_valid) begin
            if (pending_vertices.size() == 0) begin
                report_mismatch("vertex with nothing expected");
            end else begin
                e = pending_vertices.pop_front();
                if (o_ndc_x !== e.ndc_x)
                    report_mismatch($sformatf("ndc_x %0d exp %0d", o_ndc_x, e.ndc_x));
                if (o_ndc_y !== e.ndc_y)
                    report_mismatch($sformatf("ndc_y %0d exp %0d", o_ndc_y, e.ndc_y));
                if (o_tex_u !== e.tex_u)
                    report_mismatch($sformatf("tex_u %0d exp %0d", o_tex_u, e.tex_u));
                if (o_tex_v !== e.tex_v)
                    report_mismatch($sformatf("tex_v %0d exp %0d", o_tex_v, e.tex_v));
                if (o_vertex_color !== e.color)
                    report_mismatch($sformatf("color %h exp %h", o_vertex_color, e.color));
                if (o_last_vertex !== e.last)
                    report_mismatch($sformatf("last %b exp %b", o_last_vertex, e.last));
            end
        end
    end

    initial begin
        mismatch_count = 0;
        allow_idle = 1'b1;
        i_rst_n = 1'b0;
        start = 1'b0;
        {pos_x, pos_y, rect_w, rect_h} = '0;
        {color_rgba, rotation, src_x, src_y, src_w, src_h} = '0;
        {psel, penable, pwrite} = '0;
        paddr = '0;
        pwdata = '0;
        vp_w_q = 14'd1920;
        vp_h_q = 14'd1080;
        tex_w_q = 13'd256;
        tex_h_q = 13'd256;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_sprites();
        test_register_settings();
        test_random_sprites(180);

        if (pending_vertices.size() != 0)
            report_mismatch($sformatf("%0d vertices never came", pending_vertices.size()));
        if (mismatch_count == 0) begin
            $display("[sprite_quad_vertex_setup] OK");
        end else begin
            $display("[sprite_quad_vertex_setup] ERROR");
        end
        $finish;
    end
endmodule
